[hdl/hti_pkg.sv]
package hti_pkg;

   // store size defaults
   localparam int MAX_ROWS_DEF = 256;
   localparam int MAX_COLS_DEF = 256;

   // field widths
   localparam int GRID_W     = 9;
   localparam int SQ_W       = 16;
   localparam int IDX_W      = 16;
   localparam int SAMPLE_W   = 8;
   localparam int POS_W      = 24;
   localparam int HEIGHT_W   = 24;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [SQ_W-1:0] SQUARE_SIZE_RESET  = 16'd256;
   localparam logic [SQ_W-1:0] HEIGHT_SCALE_RESET = 16'd256;

   // item kinds
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // register map
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GRID_ROWS    = 2'd0,
      CSR_GRID_COLS    = 2'd1,
      CSR_SQUARE_SIZE  = 2'd2,
      CSR_HEIGHT_SCALE = 2'd3
   } csr_addr_type;

endpackage

[hdl/hti_if.sv]
interface hti_req_if;
   import hti_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [IDX_W-1:0]           cell_index;
   logic [SAMPLE_W-1:0]        height_sample;
   logic signed [POS_W-1:0]    pos_x;
   logic signed [POS_W-1:0]    pos_z;
   modport source (output valid, mode, cell_index, height_sample, pos_x, pos_z, input ready);
   modport sink (input valid, mode, cell_index, height_sample, pos_x, pos_z, output ready);
endinterface

interface hti_rsp_if;
   import hti_pkg::*;
   logic                valid;
   logic                ready;
   logic [HEIGHT_W-1:0] terrain_height;
   logic                in_bound;
   modport source (output valid, terrain_height, in_bound, input ready);
   modport sink (input valid, terrain_height, in_bound, output ready);
endinterface

interface hti_csr_if;
   import hti_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

[hdl/heightmap_triangle_interpolation.sv]
// Heightmap interpolator: a load word (mode 0) writes one 8-bit sample into the height store and
// gives no response; a query word (mode 1) gives one response with the Q16.8 terrain height at
// (pos_x, pos_z) and the in_bound flag. Loads are taken one per cycle while no query holds the
// store. A query holds the single port of the height store while it reads its four corner
// samples in turn, so a new query enters the store only after those reads are done; all other
// stages (bounds test, cell divide, corner address, operand select, interpolation multiplies,
// numerator sum and the final divide by twice the square size) are pipelined and take a new
// word every cycle unless the output stalls. Samples never loaded read as undefined. Write
// configuration only while no word is in flight.
module heightmap_triangle_interpolation #(
   parameter int MAX_ROWS = hti_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = hti_pkg::MAX_COLS_DEF
) (
   input logic        clock,
   input logic        reset,
   hti_csr_if.sink    csr_if,
   hti_req_if.sink    req_if,
   hti_rsp_if.source  rsp_if
);
   import hti_pkg::*;

   localparam int DEPTH     = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CQ_W      = 9;   // cell quotient bits
   localparam int CD_STEPS  = 3;
   localparam int CD_STAGES = CQ_W / CD_STEPS;
   localparam int HQ_W      = 24;  // height quotient bits
   localparam int HD_STEPS  = 3;
   localparam int HD_STAGES = HQ_W / HD_STEPS;
   localparam logic [1:0] LAST_READ = 2'd3;

   typedef struct packed {
      logic                    mode;
      logic [IDX_W-1:0]        idx;
      logic [SAMPLE_W-1:0]     sample;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_z;
   } in_type;

   typedef struct packed {
      logic                mode;
      logic [IDX_W-1:0]    idx;
      logic [SAMPLE_W-1:0] sample;
      logic                in_map;
      logic [25:0]         x_rem;
      logic [25:0]         z_rem;
      logic [CQ_W-1:0]     col;
      logic [CQ_W-1:0]     row;
   } cdiv_type;

   typedef struct packed {
      logic                mode;
      logic [IDX_W-1:0]    idx;
      logic [SAMPLE_W-1:0] sample;
      logic                in_map;
      logic                up;
      logic [16:0]         fx;
      logic [16:0]         fz;
      logic [3:0]          cv;
      logic [3:0][19:0]    addr;
   } corner_type;

   typedef struct packed {
      logic        in_map;
      logic        up;
      logic [16:0] fx;
      logic [16:0] fz;
      logic [3:0]  cv;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
   } gather_type;

   typedef struct packed {
      logic              in_map;
      logic [7:0]        base;
      logic signed [8:0] u1;
      logic [16:0]       m1;
      logic signed [8:0] u2;
      logic [16:0]       m2;
   } oper_type;

   typedef struct packed {
      logic               in_map;
      logic [24:0]        pr0;
      logic signed [26:0] pr1;
      logic signed [26:0] pr2;
   } prod_type;

   typedef struct packed {
      logic        in_map;
      logic [24:0] num;
   } num_type;

   typedef struct packed {
      logic            in_map;
      logic [40:0]     rem;
      logic [HQ_W-1:0] quo;
   } hdiv_type;

   // configuration registers and derived terms
   logic [GRID_W-1:0] rows_ff, cols_ff;
   logic [SQ_W-1:0]   sq_ff, scale_ff;
   logic [24:0]       w_ff, h_ff;
   logic [16:0]       dn_ff;
   logic              sq_zero_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= '0;
         cols_ff  <= '0;
         sq_ff    <= SQUARE_SIZE_RESET;
         scale_ff <= HEIGHT_SCALE_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_addr_type'(csr_if.addr))
            CSR_GRID_ROWS:    rows_ff  <= csr_if.data[GRID_W-1:0];
            CSR_GRID_COLS:    cols_ff  <= csr_if.data[GRID_W-1:0];
            CSR_SQUARE_SIZE:  sq_ff    <= csr_if.data;
            CSR_HEIGHT_SCALE: scale_ff <= csr_if.data;
            default: ;
         endcase
      end
   end

   // map size in Q.8 and doubled square size
   always_ff @(posedge clock) begin
      w_ff       <= 25'(cols_ff) * 25'(sq_ff);
      h_ff       <= 25'(rows_ff) * 25'(sq_ff);
      dn_ff      <= {sq_ff, 1'b0};
      sq_zero_ff <= (sq_ff == '0);
   end

   // stage handshake
   logic s0_free, a_free, m_free, g_free, p_free, q_free, n_free, h_free, o_free;
   logic [CD_STAGES:0] cd_free;
   logic [HD_STAGES:0] hd_free;
   logic leave_m;

   // input register
   in_type s0_ff;
   logic   s0_v_ff;

   assign req_if.ready = s0_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (s0_free) begin
         s0_v_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_free) begin
         s0_ff.mode   <= req_if.mode;
         s0_ff.idx    <= req_if.cell_index;
         s0_ff.sample <= req_if.height_sample;
         s0_ff.pos_x  <= req_if.pos_x;
         s0_ff.pos_z  <= req_if.pos_z;
      end
   end

   // center the point (doubled coordinates) and test the bounds
   cdiv_type         cd_ff [CD_STAGES+1];
   cdiv_type         cd_in [CD_STAGES+1];
   logic [CD_STAGES:0] cd_v_ff;
   logic signed [26:0] x1, z1;

   always_comb begin
      x1 = 27'(signed'({s0_ff.pos_x, 1'b0})) + signed'({2'b00, w_ff});
      z1 = signed'({2'b00, h_ff}) - 27'(signed'({s0_ff.pos_z, 1'b0}));
      cd_in[0].mode   = s0_ff.mode;
      cd_in[0].idx    = s0_ff.idx;
      cd_in[0].sample = s0_ff.sample;
      cd_in[0].in_map = !sq_zero_ff && (x1 >= 0) && (x1 < signed'({1'b0, w_ff, 1'b0}))
                        && (z1 >= 0) && (z1 < signed'({1'b0, h_ff, 1'b0}));
      cd_in[0].x_rem  = x1[25:0];
      cd_in[0].z_rem  = z1[25:0];
      cd_in[0].col    = '0;
      cd_in[0].row    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_v_ff[0] <= 1'b0;
      end else if (cd_free[0]) begin
         cd_v_ff[0] <= s0_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cd_free[0]) begin
         cd_ff[0] <= cd_in[0];
      end
   end

   assign s0_free = !s0_v_ff || cd_free[0];

   // cell divide: restoring, three quotient bits per stage
   for (genvar j = 1; j <= CD_STAGES; j++) begin : g_cdiv
      always_comb begin
         logic [25:0] tr;
         cd_in[j] = cd_ff[j-1];
         for (int s = 0; s < CD_STEPS; s++) begin
            tr = 26'(dn_ff) << (CQ_W - 1 - (j - 1) * CD_STEPS - s);
            if (cd_in[j].x_rem >= tr) begin
               cd_in[j].x_rem = cd_in[j].x_rem - tr;
               cd_in[j].col   = {cd_in[j].col[CQ_W-2:0], 1'b1};
            end else begin
               cd_in[j].col   = {cd_in[j].col[CQ_W-2:0], 1'b0};
            end
            if (cd_in[j].z_rem >= tr) begin
               cd_in[j].z_rem = cd_in[j].z_rem - tr;
               cd_in[j].row   = {cd_in[j].row[CQ_W-2:0], 1'b1};
            end else begin
               cd_in[j].row   = {cd_in[j].row[CQ_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cd_v_ff[j] <= 1'b0;
         end else if (cd_free[j]) begin
            cd_v_ff[j] <= cd_v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (cd_free[j]) begin
            cd_ff[j] <= cd_in[j];
         end
      end
   end

   for (genvar k = 0; k <= CD_STAGES; k++) begin : g_cfree
      if (k == CD_STAGES) begin : g_last
         assign cd_free[k] = !cd_v_ff[k] || a_free;
      end else begin : g_mid
         assign cd_free[k] = !cd_v_ff[k] || cd_free[k+1];
      end
   end

   // corner addresses, corner validity and triangle choice
   corner_type a_ff, a_in;
   logic       a_v_ff;
   logic [19:0] base_idx;

   always_comb begin
      base_idx    = 20'(cd_ff[CD_STAGES].row) * 20'(cols_ff) + 20'(cd_ff[CD_STAGES].col);
      a_in.mode   = cd_ff[CD_STAGES].mode;
      a_in.idx    = cd_ff[CD_STAGES].idx;
      a_in.sample = cd_ff[CD_STAGES].sample;
      a_in.in_map = cd_ff[CD_STAGES].in_map;
      a_in.fx     = cd_ff[CD_STAGES].x_rem[16:0];
      a_in.fz     = cd_ff[CD_STAGES].z_rem[16:0];
      a_in.up     = (18'(a_in.fx) + 18'(a_in.fz)) < 18'(dn_ff);
      a_in.addr[0] = base_idx;
      a_in.addr[1] = base_idx + 20'd1;
      a_in.addr[2] = base_idx + 20'(cols_ff);
      a_in.addr[3] = base_idx + 20'(cols_ff) + 20'd1;
      a_in.cv[0] = (cd_ff[CD_STAGES].row < rows_ff) && (cd_ff[CD_STAGES].col < cols_ff)
                   && (32'(a_in.addr[0]) < 32'(DEPTH));
      a_in.cv[1] = (cd_ff[CD_STAGES].row < rows_ff)
                   && (10'(cd_ff[CD_STAGES].col) + 10'd1 < 10'(cols_ff))
                   && (32'(a_in.addr[1]) < 32'(DEPTH));
      a_in.cv[2] = (10'(cd_ff[CD_STAGES].row) + 10'd1 < 10'(rows_ff))
                   && (cd_ff[CD_STAGES].col < cols_ff)
                   && (32'(a_in.addr[2]) < 32'(DEPTH));
      a_in.cv[3] = (10'(cd_ff[CD_STAGES].row) + 10'd1 < 10'(rows_ff))
                   && (10'(cd_ff[CD_STAGES].col) + 10'd1 < 10'(cols_ff))
                   && (32'(a_in.addr[3]) < 32'(DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (a_free) begin
         a_v_ff <= cd_v_ff[CD_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (a_free) begin
         a_ff <= a_in;
      end
   end

   assign a_free = !a_v_ff || m_free;

   // height store: loads write, queries read four corners in turn
   corner_type m_ff;
   logic       m_v_ff;
   logic [1:0] cnt_ff;
   logic [7:0] cap_a_ff, cap_b_ff, q_ff;
   logic [7:0] store_mem [DEPTH];
   logic       mem_we, mem_re;
   logic [ADDR_W-1:0] mem_addr;

   assign leave_m = m_v_ff && ((m_ff.mode == MODE_LOAD) || ((cnt_ff == LAST_READ) && g_free));
   assign m_free  = !m_v_ff || leave_m;
   assign mem_we  = m_v_ff && (m_ff.mode == MODE_LOAD) && (32'(m_ff.idx) < 32'(DEPTH));
   assign mem_re  = m_v_ff && (m_ff.mode == MODE_QUERY) && ((cnt_ff != LAST_READ) || g_free);
   assign mem_addr = (m_ff.mode == MODE_LOAD) ? ADDR_W'(m_ff.idx) : ADDR_W'(m_ff.addr[cnt_ff]);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= m_ff.sample;
      end
      if (mem_re) begin
         q_ff <= store_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (m_free) begin
         m_v_ff <= a_v_ff;
         cnt_ff <= '0;
      end else if ((m_ff.mode == MODE_QUERY) && (cnt_ff != LAST_READ)) begin
         cnt_ff <= cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (m_free) begin
         m_ff <= a_ff;
      end
   end

   // corner a is captured from the store output while the read counter is one, b while it is two
   always_ff @(posedge clock) begin
      if (m_v_ff && (cnt_ff == 2'd1)) begin
         cap_a_ff <= q_ff;
      end
      if (m_v_ff && (cnt_ff == 2'd2)) begin
         cap_b_ff <= q_ff;
      end
   end

   // gather: corner c comes on entry, d in the cycle after
   gather_type g_ff;
   logic       g_v_ff, need_d_ff;
   logic [7:0] d_ff, d_eff;

   assign d_eff  = need_d_ff ? q_ff : d_ff;
   assign g_free = !g_v_ff || p_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff    <= 1'b0;
         need_d_ff <= 1'b0;
      end else if (g_free) begin
         g_v_ff    <= m_v_ff && (m_ff.mode == MODE_QUERY) && (cnt_ff == LAST_READ);
         need_d_ff <= 1'b1;
      end else begin
         need_d_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (g_free) begin
         g_ff.in_map <= m_ff.in_map;
         g_ff.up     <= m_ff.up;
         g_ff.fx     <= m_ff.fx;
         g_ff.fz     <= m_ff.fz;
         g_ff.cv     <= m_ff.cv;
         g_ff.a      <= cap_a_ff;
         g_ff.b      <= cap_b_ff;
         g_ff.c      <= q_ff;
      end else begin
         d_ff <= d_eff;
      end
   end

   // mask corners outside the grid and pick the triangle's operands
   oper_type   p_ff, p_in;
   logic       p_v_ff;
   logic [7:0] ca, cb, cc, cdd;

   always_comb begin
      ca  = g_ff.cv[0] ? g_ff.a : 8'd0;
      cb  = g_ff.cv[1] ? g_ff.b : 8'd0;
      cc  = g_ff.cv[2] ? g_ff.c : 8'd0;
      cdd = g_ff.cv[3] ? d_eff  : 8'd0;
      p_in.in_map = g_ff.in_map;
      if (g_ff.up) begin
         p_in.base = ca;
         p_in.u1   = signed'({1'b0, cb}) - signed'({1'b0, ca});
         p_in.m1   = g_ff.fx;
         p_in.u2   = signed'({1'b0, cc}) - signed'({1'b0, ca});
         p_in.m2   = g_ff.fz;
      end else begin
         p_in.base = cdd;
         p_in.u1   = signed'({1'b0, cc}) - signed'({1'b0, cdd});
         p_in.m1   = dn_ff - g_ff.fx;
         p_in.u2   = signed'({1'b0, cb}) - signed'({1'b0, cdd});
         p_in.m2   = dn_ff - g_ff.fz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (p_free) begin
         p_v_ff <= g_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p_free) begin
         p_ff <= p_in;
      end
   end

   assign p_free = !p_v_ff || q_free;

   // interpolation products
   prod_type q_ff2, q_in;
   logic     q_v_ff;

   always_comb begin
      q_in.in_map = p_ff.in_map;
      q_in.pr0    = 25'(p_ff.base) * 25'(dn_ff);
      q_in.pr1    = 27'(p_ff.u1) * 27'(signed'({1'b0, p_ff.m1}));
      q_in.pr2    = 27'(p_ff.u2) * 27'(signed'({1'b0, p_ff.m2}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_v_ff <= 1'b0;
      end else if (q_free) begin
         q_v_ff <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (q_free) begin
         q_ff2 <= q_in;
      end
   end

   assign q_free = !q_v_ff || n_free;

   // numerator sum, clamped at zero
   num_type            n_ff, n_in;
   logic               n_v_ff;
   logic signed [27:0] sum;

   always_comb begin
      sum = signed'({3'b000, q_ff2.pr0}) + 28'(q_ff2.pr1) + 28'(q_ff2.pr2);
      n_in.in_map = q_ff2.in_map;
      n_in.num    = (sum < 0) ? 25'd0 : sum[24:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_v_ff <= 1'b0;
      end else if (n_free) begin
         n_v_ff <= q_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (n_free) begin
         n_ff <= n_in;
      end
   end

   assign n_free = !n_v_ff || h_free;

   // scale by the height scale, then divide by twice the square size
   hdiv_type           hd_ff [HD_STAGES+1];
   hdiv_type           hd_in [HD_STAGES+1];
   logic [HD_STAGES:0] hd_v_ff;

   always_comb begin
      hd_in[0].in_map = n_ff.in_map;
      hd_in[0].rem    = 41'(n_ff.num) * 41'(scale_ff);
      hd_in[0].quo    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hd_v_ff[0] <= 1'b0;
      end else if (h_free) begin
         hd_v_ff[0] <= n_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (h_free) begin
         hd_ff[0] <= hd_in[0];
      end
   end

   assign h_free = hd_free[0];

   // the quotient stays below 2^24 since the sum is at most 255 times the divisor and the scale below 2^16
   for (genvar j = 1; j <= HD_STAGES; j++) begin : g_hdiv
      always_comb begin
         logic [40:0] tr;
         hd_in[j] = hd_ff[j-1];
         for (int s = 0; s < HD_STEPS; s++) begin
            tr = 41'(dn_ff) << (HQ_W - 1 - (j - 1) * HD_STEPS - s);
            if (hd_in[j].rem >= tr) begin
               hd_in[j].rem = hd_in[j].rem - tr;
               hd_in[j].quo = {hd_in[j].quo[HQ_W-2:0], 1'b1};
            end else begin
               hd_in[j].quo = {hd_in[j].quo[HQ_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            hd_v_ff[j] <= 1'b0;
         end else if (hd_free[j]) begin
            hd_v_ff[j] <= hd_v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (hd_free[j]) begin
            hd_ff[j] <= hd_in[j];
         end
      end
   end

   for (genvar k = 0; k <= HD_STAGES; k++) begin : g_hfree
      if (k == HD_STAGES) begin : g_last
         assign hd_free[k] = !hd_v_ff[k] || o_free;
      end else begin : g_mid
         assign hd_free[k] = !hd_v_ff[k] || hd_free[k+1];
      end
   end

   // output register
   logic                o_v_ff, o_bound_ff;
   logic [HEIGHT_W-1:0] o_height_ff;

   assign o_free = !o_v_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (o_free) begin
         o_v_ff <= hd_v_ff[HD_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (o_free) begin
         o_bound_ff  <= hd_ff[HD_STAGES].in_map;
         o_height_ff <= hd_ff[HD_STAGES].in_map ? hd_ff[HD_STAGES].quo : '0;
      end
   end

   assign rsp_if.valid          = o_v_ff;
   assign rsp_if.terrain_height = o_height_ff;
   assign rsp_if.in_bound       = o_bound_ff;

endmodule

[hdl/hti_checker.sv]
module hti_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] terrain_height,
   input logic        in_bound
);

   // a response waiting for the sink stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(terrain_height) && $stable(in_bound))
      else $error("response word changed while stalled");

   // points off the map report zero height
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !in_bound |-> terrain_height == 24'd0)
      else $error("nonzero height outside the map");

   // the pipeline is empty right after reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

endmodule

bind heightmap_triangle_interpolation hti_checker u_hti_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .terrain_height (rsp_if.terrain_height),
   .in_bound       (rsp_if.in_bound)
);

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import hti_pkg::*;

   localparam int  STORE_DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF;
   localparam longint HEIGHT_MAX = 64'd16777215;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int  DRAIN_CYCLES = 40;

   typedef struct {
      logic [HEIGHT_W-1:0] terrain_height;
      logic                in_bound;
   } height_result_type;

   // expected heights kept in order, with a private copy of store and registers
   class height_scoreboard;
      logic [SAMPLE_W-1:0] samples[STORE_DEPTH];
      bit                  written[STORE_DEPTH];
      logic [GRID_W-1:0]   rows, cols;
      logic [SQ_W-1:0]     sq_size, scale;
      height_result_type   pending[$];
      int                  mismatches;

      function void init();
         rows = '0;
         cols = '0;
         sq_size = SQUARE_SIZE_RESET;
         scale = HEIGHT_SCALE_RESET;
         mismatches = 0;
      endfunction

      function void write_reg(csr_addr_type addr, logic [CSR_DATA_W-1:0] data);
         case (addr)
            CSR_GRID_ROWS:    rows = data[GRID_W-1:0];
            CSR_GRID_COLS:    cols = data[GRID_W-1:0];
            CSR_SQUARE_SIZE:  sq_size = data;
            CSR_HEIGHT_SCALE: scale = data;
            default: ;
         endcase
      endfunction

      function longint corner_height(longint r, longint c);
         longint idx;
         if (r < 0 || c < 0 || r >= rows || c >= cols) return 0;
         idx = r * cols + c;
         if (idx >= STORE_DEPTH) return 0;
         return samples[idx];
      endfunction

      // index of an in-grid corner of the query that was never loaded, or -1
      function int missing_corner(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] pz);
         longint w, h, x, z, dn, r, c, idx;
         w = longint'(cols) * longint'(sq_size);
         h = longint'(rows) * longint'(sq_size);
         x = 2 * longint'(px) + w;
         z = h - 2 * longint'(pz);
         if (sq_size == 0 || x < 0 || x >= 2 * w || z < 0 || z >= 2 * h) return -1;
         dn = 2 * longint'(sq_size);
         for (int k = 0; k < 4; k++) begin
            r = z / dn + k / 2;
            c = x / dn + k % 2;
            if (r < rows && c < cols) begin
               idx = r * cols + c;
               if (idx < STORE_DEPTH && !written[idx]) return int'(idx);
            end
         end
         return -1;
      endfunction

      // note an accepted word: loads update the store, queries push a height
      function void note_word(logic mode, logic [IDX_W-1:0] idx, logic [SAMPLE_W-1:0] smp,
                              logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] pz);
         longint w, h, x, z, dn, col, row, fx, fz, a, b, c, d, num, res;
         height_result_type r;
         if (mode == MODE_LOAD) begin
            samples[idx] = smp;
            written[idx] = 1'b1;
            return;
         end
         w = longint'(cols) * longint'(sq_size);
         h = longint'(rows) * longint'(sq_size);
         x = 2 * longint'(px) + w;
         z = h - 2 * longint'(pz);
         if (sq_size == 0 || x < 0 || x >= 2 * w || z < 0 || z >= 2 * h) begin
            r.terrain_height = '0;
            r.in_bound = 1'b0;
            pending.push_back(r);
            return;
         end
         dn = 2 * longint'(sq_size);
         col = x / dn;
         row = z / dn;
         fx = x - col * dn;
         fz = z - row * dn;
         a = corner_height(row, col);
         b = corner_height(row, col + 1);
         c = corner_height(row + 1, col);
         d = corner_height(row + 1, col + 1);
         // upper-left or lower-right triangle
         if (fx + fz < dn) num = a * dn + (b - a) * fx + (c - a) * fz;
         else num = d * dn + (c - d) * (dn - fx) + (b - d) * (dn - fz);
         if (num < 0) num = 0;
         res = (num * longint'(scale)) / dn;
         if (res > HEIGHT_MAX) res = HEIGHT_MAX;
         r.terrain_height = res[HEIGHT_W-1:0];
         r.in_bound = 1'b1;
         pending.push_back(r);
      endfunction

      function void check_height(logic [HEIGHT_W-1:0] th, logic ib);
         height_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response height=%0d flag=%0b", th, ib);
            return;
         end
         e = pending.pop_front();
         if (th !== e.terrain_height || ib !== e.in_bound) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected height=%0d flag=%0b, got height=%0d flag=%0b",
                        e.terrain_height, e.in_bound, th, ib);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   longint cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int words_sent = 0;

   hti_req_if req_bus();
   hti_rsp_if rsp_bus();
   hti_csr_if csr_bus();

   height_scoreboard sb;

   heightmap_triangle_interpolation u_top (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_bus),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_height(rsp_bus.terrain_height, rsp_bus.in_bound);
   end

   // receiver stall pattern, switching at random among four characters
   always @(posedge clock) begin
      if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         2: rsp_bus.ready <= (cycles % 5 == 0);
         default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   task automatic write_csr(csr_addr_type addr, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.addr <= addr;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(addr, data);
   endtask

   task automatic wait_idle();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_map(int rows, int cols, int sq, int scale);
      req_bus.valid <= 1'b0;
      wait_idle();
      write_csr(CSR_GRID_ROWS, CSR_DATA_W'(rows));
      write_csr(CSR_GRID_COLS, CSR_DATA_W'(cols));
      write_csr(CSR_SQUARE_SIZE, CSR_DATA_W'(sq));
      write_csr(CSR_HEIGHT_SCALE, CSR_DATA_W'(scale));
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // send one word; bursts and gaps unless told to stream
   task automatic send_word(logic mode, logic [IDX_W-1:0] idx, logic [SAMPLE_W-1:0] smp,
                            logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] pz,
                            bit stream);
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.cell_index <= idx;
      req_bus.height_sample <= smp;
      req_bus.pos_x <= px;
      req_bus.pos_z <= pz;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_word(mode, idx, smp, px, pz);
      words_sent++;
      if (stream) return;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 20);
         if ($urandom_range(0, 2) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   // query a point, first loading any of its grid corners not yet written
   task automatic send_query(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] pz);
      int miss;
      miss = sb.missing_corner(px, pz);
      while (miss >= 0) begin
         send_word(MODE_LOAD, IDX_W'(miss), SAMPLE_W'($urandom), '0, '0, 1'b0);
         miss = sb.missing_corner(px, pz);
      end
      send_word(MODE_QUERY, IDX_W'($urandom), SAMPLE_W'($urandom), px, pz, 1'b0);
   endtask

   function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
      if (v > 8388607) return 24'sd8388607;
      if (v < -8388608) return -24'sd8388608;
      return v[POS_W-1:0];
   endfunction

   task automatic query_xz(longint x2, longint z2);
      longint w, h;
      w = longint'(sb.cols) * longint'(sb.sq_size);
      h = longint'(sb.rows) * longint'(sb.sq_size);
      send_query(clamp_pos((x2 - w) >>> 1), clamp_pos((h - z2) >>> 1));
   endtask

   // random mix: mostly in-map queries, some loads and some raw noise
   task automatic random_phase(int count);
      longint span_x, span_z;
      int sel, first;
      bit paused;
      first = words_sent;
      paused = 1'b0;
      while (words_sent - first < count) begin
         span_x = 2 * longint'(sb.cols) * longint'(sb.sq_size);
         span_z = 2 * longint'(sb.rows) * longint'(sb.sq_size);
         sel = $urandom_range(0, 99);
         if (!paused && (words_sent - first >= count / 2)) begin
            paused = 1'b1;
            req_bus.valid <= 1'b0;
            wait_idle();
         end
         if (sel < 25)
            send_word(MODE_LOAD, IDX_W'($urandom), SAMPLE_W'($urandom), POS_W'($urandom),
                      POS_W'($urandom), 1'b0);
         else if (sel < 35)
            send_query(POS_W'($urandom), POS_W'($urandom));
         else
            query_xz(longint'({$urandom} % (span_x + 17)) - 8,
                     longint'({$urandom} % (span_z + 17)) - 8);
      end
   endtask

   initial begin
      sb = new();
      sb.init();
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_LOAD;
      req_bus.cell_index = '0;
      req_bus.height_sample = '0;
      req_bus.pos_x = '0;
      req_bus.pos_z = '0;
      csr_bus.valid = 1'b0;
      csr_bus.addr = CSR_GRID_ROWS;
      csr_bus.data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: small map with corners, edges, triangles and extreme samples, then empty, zero-square and large maps
      set_map(4, 4, 256, 256);
      send_word(MODE_LOAD, 16'd0, 8'hff, '0, '0, 1'b0);
      send_word(MODE_LOAD, 16'd1, 8'h00, '0, '0, 1'b0);
      send_word(MODE_LOAD, 16'd5, 8'hff, '0, '0, 1'b0);
      send_word(MODE_LOAD, 16'hffff, 8'h5a, '0, '0, 1'b0);
      query_xz(0, 0);
      query_xz(2047, 2047);
      query_xz(2048, 100);
      query_xz(100, 2048);
      query_xz(-1, 100);
      query_xz(100, -1);
      query_xz(100, 300);
      query_xz(300, 100);
      query_xz(511, 511);
      query_xz(1024, 1024);
      send_query(24'sh7fffff, -24'sh800000);
      send_query(-24'sh800000, 24'sh7fffff);
      set_map(0, 0, 256, 256);
      query_xz(0, 0);
      send_query('0, '0);
      set_map(4, 4, 0, 256);
      send_query('0, '0);
      set_map(256, 256, 65535, 65535);
      query_xz(1000, 1000);
      send_query(24'sh7fffff, 24'sh7fffff);
      send_query(-24'sh800000, -24'sh800000);

      // random phases over several register settings
      random_phase(200);
      set_map(256, 256, 1, 65535);
      random_phase(200);
      set_map(2, 2, 1, 0);
      random_phase(150);
      set_map(256, 256, 256, 256);
      random_phase(250);
      set_map(17, 9, 300, 1000);
      random_phase(200);
      set_map(1, 3, 65535, 12345);
      random_phase(150);
      set_map(256, 0, 512, 256);
      random_phase(100);
      for (int p = 0; p < 3; p++) begin
         set_map($urandom_range(0, 256), $urandom_range(0, 256), $urandom_range(1, 65535),
                 $urandom_range(0, 65535));
         random_phase(200);
      end

      req_bus.valid <= 1'b0;
      wait_idle();
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[heightmap_triangle_interpolation.f]
hdl/hti_pkg.sv
hdl/hti_if.sv
hdl/heightmap_triangle_interpolation.sv
hdl/hti_checker.sv
dv/tb.sv
